>>> rtl/fctc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Floor caster package
// Shared types and fixed constants of the floor and ceiling texture caster.
// ----------------------------------------------------------------------------
package fctc_pkg;

   localparam int TEX_DEPTH = 4096;
   localparam int TEX_AW    = 12;
   localparam int COLOR_W   = 24;
   localparam int SCAN_W    = 12;
   localparam int OUT_W     = 11;
   localparam int CSR_IW    = 3;
   localparam int CSR_DW    = 24;

   localparam logic [17:0] DIR_X_RESET   = 18'h30000;
   localparam logic [17:0] PLANE_Y_RESET = 18'd43254;
   localparam logic [11:0] WIDTH_RESET   = 12'd640;
   localparam logic [11:0] HEIGHT_RESET  = 12'd480;
   localparam logic [11:0] ROW_RESET     = 12'd241;

   typedef enum logic [2:0] {
      CSR_DIR_X   = 3'd0,
      CSR_DIR_Y   = 3'd1,
      CSR_PLANE_X = 3'd2,
      CSR_PLANE_Y = 3'd3,
      CSR_POS_X   = 3'd4,
      CSR_POS_Y   = 3'd5,
      CSR_WIDTH   = 3'd6,
      CSR_HEIGHT  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [17:0] dir_x;
      logic [17:0] dir_y;
      logic [17:0] plane_x;
      logic [17:0] plane_y;
      logic [23:0] pos_x;
      logic [23:0] pos_y;
      logic [11:0] width;
      logic [11:0] height;
   } camera_type;

   typedef struct packed {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] step_x;
      logic [31:0] step_y;
   } row_result_type;

   typedef enum logic [2:0] {
      RS_IDLE,
      RS_RD,
      RS_MUL_SX,
      RS_DIV_SX,
      RS_MUL_SY,
      RS_DIV_SY,
      RS_MUL_PX,
      RS_MUL_PY
   } rs_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_TEX,
      ST_ADDR,
      ST_DATA
   } st_type;

endpackage

>>> rtl/floor_ceiling_texture_caster.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Floor and ceiling texture caster
// Scans the floor rows of the screen and gives one textured pixel per pixel
// word, with the mirrored ceiling row; load words fill the texture memory.
//
//   Channel  Handshake          Direction  Word
//   req      req_valid/stall    in         op, texel index, texel color
//   rsp      rsp_valid/stall    out        column, rows, color, frame end
//   csr      csr_valid/ready    in         register index, write data
//
// A pixel word passes the texture coordinate, address and data steps; the
// first pixel of a row first waits for the row setup unit (serial divider
// and multiplier). The output register lets the next word be taken while
// a result waits. Reset is synchronous; the texture memory is not cleared.
// A stalled result holds the block in its last step only.
// ----------------------------------------------------------------------------
module floor_ceiling_texture_caster #(
   parameter int TEX_WIDTH  = 64,
   parameter int TEX_HEIGHT = 64,
   parameter int FRAC_BITS  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_op,
   input  logic [11:0]                    req_texel_index,
   input  logic [23:0]                    req_texel_color,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [10:0]                    rsp_column,
   output logic [10:0]                    rsp_floor_row,
   output logic [10:0]                    rsp_mirror_row,
   output logic [23:0]                    rsp_pixel_color,
   output logic                           rsp_frame_end,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [fctc_pkg::CSR_IW-1:0]    csr_index,
   input  logic [fctc_pkg::CSR_DW-1:0]    csr_data
);

   localparam int TXW = $clog2(TEX_WIDTH);
   localparam int TYW = $clog2(TEX_HEIGHT);
   localparam int TPW = FRAC_BITS + 11;

   fctc_pkg::st_type         state_ff, state_in;
   fctc_pkg::camera_type     cam_ff;
   fctc_pkg::row_result_type setup_res;

   logic [11:0]  row_ff, col_ff;
   logic [11:0]  first, r1, c1, r2, c2, rr, nr, nc, nrr;
   logic         accept, pixel, empty, oor, out_free;
   logic         setup_start, setup_done, rd_en, mem_wr;
   logic [31:0]  fpos_x_ff, fpos_y_ff, fstep_x_ff, fstep_y_ff;
   logic [TPW-1:0] txp, typ;
   logic [TXW-1:0] tx_ff;
   logic [TYW-1:0] ty_ff;
   logic [20:0]  lin;
   logic [23:0]  rd_data;
   logic         rsp_valid_ff;
   logic [10:0]  col_out_ff, row_out_ff, mir_out_ff;
   logic [23:0]  color_out_ff;
   logic         fend_out_ff;
   logic [11:0]  mirror;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_ff.dir_x   <= fctc_pkg::DIR_X_RESET;
         cam_ff.dir_y   <= '0;
         cam_ff.plane_x <= '0;
         cam_ff.plane_y <= fctc_pkg::PLANE_Y_RESET;
         cam_ff.pos_x   <= '0;
         cam_ff.pos_y   <= '0;
         cam_ff.width   <= fctc_pkg::WIDTH_RESET;
         cam_ff.height  <= fctc_pkg::HEIGHT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            fctc_pkg::CSR_DIR_X:   cam_ff.dir_x   <= csr_data[17:0];
            fctc_pkg::CSR_DIR_Y:   cam_ff.dir_y   <= csr_data[17:0];
            fctc_pkg::CSR_PLANE_X: cam_ff.plane_x <= csr_data[17:0];
            fctc_pkg::CSR_PLANE_Y: cam_ff.plane_y <= csr_data[17:0];
            fctc_pkg::CSR_POS_X:   cam_ff.pos_x   <= csr_data;
            fctc_pkg::CSR_POS_Y:   cam_ff.pos_y   <= csr_data;
            fctc_pkg::CSR_WIDTH:   cam_ff.width   <= csr_data[11:0];
            fctc_pkg::CSR_HEIGHT:  cam_ff.height  <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      accept = req_valid && !req_stall;
      pixel  = req_op;
      empty  = (cam_ff.width == '0) || (cam_ff.height < 12'd3);
      first  = {1'b0, cam_ff.height[11:1]} + 12'd1;
      oor    = (row_ff < first) || (row_ff >= cam_ff.height);
      r1     = oor ? first : row_ff;
      c1     = oor ? '0 : col_ff;
      rr     = r1 + 12'd1;
      if (c1 >= cam_ff.width) begin
         c2 = '0;
         r2 = (rr >= cam_ff.height) ? first : rr;
      end else begin
         c2 = c1;
         r2 = r1;
      end
      nc  = col_ff + 12'd1;
      nrr = row_ff + 12'd1;
      if (nc >= cam_ff.width) begin
         nc = '0;
         nr = (nrr >= cam_ff.height) ? first : nrr;
      end else begin
         nr = row_ff;
      end
      out_free = !rsp_valid_ff || !rsp_stall;
      txp      = TPW'(fpos_x_ff[FRAC_BITS-1:0]) * TPW'(TEX_WIDTH);
      typ      = TPW'(fpos_y_ff[FRAC_BITS-1:0]) * TPW'(TEX_HEIGHT);
      lin      = 21'(TEX_WIDTH) * 21'(ty_ff) + 21'(tx_ff);
      mirror   = cam_ff.height - row_ff - 12'd1;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fctc_pkg::ST_IDLE: begin
            if (req_valid && pixel && !empty) begin
               state_in = (c2 == '0) ? fctc_pkg::ST_SETUP : fctc_pkg::ST_TEX;
            end
         end
         fctc_pkg::ST_SETUP: if (setup_done) state_in = fctc_pkg::ST_TEX;
         fctc_pkg::ST_TEX:   state_in = fctc_pkg::ST_ADDR;
         fctc_pkg::ST_ADDR:  state_in = fctc_pkg::ST_DATA;
         fctc_pkg::ST_DATA:  if (out_free) state_in = fctc_pkg::ST_IDLE;
         default:            state_in = fctc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall   = (state_ff != fctc_pkg::ST_IDLE);
      rd_en       = (state_ff == fctc_pkg::ST_ADDR);
      mem_wr      = accept && !pixel;
      setup_start = (state_ff == fctc_pkg::ST_IDLE) && req_valid && pixel && !empty &&
                    (c2 == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fctc_pkg::ST_IDLE;
         row_ff       <= fctc_pkg::ROW_RESET;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         fpos_x_ff    <= '0;
         fpos_y_ff    <= '0;
         fstep_x_ff   <= '0;
         fstep_y_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (accept && pixel && !empty) begin
            row_ff <= r2;
            col_ff <= c2;
         end
         if (state_ff == fctc_pkg::ST_SETUP && setup_done) begin
            fpos_x_ff  <= setup_res.pos_x;
            fpos_y_ff  <= setup_res.pos_y;
            fstep_x_ff <= setup_res.step_x;
            fstep_y_ff <= setup_res.step_y;
         end
         if (state_ff == fctc_pkg::ST_DATA && out_free) begin
            rsp_valid_ff <= 1'b1;
            fpos_x_ff    <= fpos_x_ff + fstep_x_ff;
            fpos_y_ff    <= fpos_y_ff + fstep_y_ff;
            col_ff       <= nc;
            row_ff       <= nr;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == fctc_pkg::ST_TEX) begin
         tx_ff <= txp[FRAC_BITS +: TXW];
         ty_ff <= typ[FRAC_BITS +: TYW];
      end
      if (state_ff == fctc_pkg::ST_DATA && out_free) begin
         col_out_ff   <= col_ff[10:0];
         row_out_ff   <= row_ff[10:0];
         mir_out_ff   <= mirror[10:0];
         color_out_ff <= rd_data;
         fend_out_ff  <= (col_ff == cam_ff.width - 12'd1) &&
                         (row_ff == cam_ff.height - 12'd1);
      end
   end

   fctc_tex_mem u_tex_mem (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (req_texel_index),
      .wr_data (req_texel_color),
      .rd_en   (rd_en),
      .rd_addr (lin[fctc_pkg::TEX_AW-1:0]),
      .rd_data (rd_data)
   );

   fctc_row_setup #(
      .FRAC_BITS (FRAC_BITS)
   ) u_row_setup (
      .clock  (clock),
      .reset  (reset),
      .start  (setup_start),
      .row    (r2),
      .cam    (cam_ff),
      .done   (setup_done),
      .result (setup_res)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_column      = col_out_ff;
   assign rsp_floor_row   = row_out_ff;
   assign rsp_mirror_row  = mir_out_ff;
   assign rsp_pixel_color = color_out_ff;
   assign rsp_frame_end   = fend_out_ff;

endmodule

>>> rtl/fctc_tex_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texture memory
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module fctc_tex_mem (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [fctc_pkg::TEX_AW-1:0]    wr_addr,
   input  logic [fctc_pkg::COLOR_W-1:0]   wr_data,
   input  logic                           rd_en,
   input  logic [fctc_pkg::TEX_AW-1:0]    rd_addr,
   output logic [fctc_pkg::COLOR_W-1:0]   rd_data
);

   logic [fctc_pkg::COLOR_W-1:0] mem [fctc_pkg::TEX_DEPTH];
   logic [fctc_pkg::COLOR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/fctc_row_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row setup unit
// Bit-serial divider and shift-add multiplier that work out the row
// distance, the floor steps and the start floor position of a row.
// ----------------------------------------------------------------------------
module fctc_row_setup #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fctc_pkg::SCAN_W-1:0]   row,
   input  fctc_pkg::camera_type          cam,
   output logic                          done,
   output fctc_pkg::row_result_type      result
);

   localparam int RDW      = 12 + FRAC_BITS;
   localparam int NW       = RDW + 3;
   localparam int PW       = RDW + 19;
   localparam int CW       = $clog2(NW);
   localparam int MUL_LAST = 18;

   fctc_pkg::rs_state_type state_ff, state_in;

   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [11:0]    rem_ff, rem_in;
   logic [NW-1:0]  quo_ff, quo_in;
   logic [11:0]    den_ff;
   logic [RDW-1:0] rd_ff, rd_src;
   logic [PW-1:0]  acc_ff, acc_in, mcand_ff;
   logic [18:0]    mplier_ff;
   logic           sign_ff;
   logic           done_ff;
   logic           is_div, is_mul, last;
   logic [12:0]    trial;
   logic           ge;
   logic [19:0]    vsel, vneg;
   logic [18:0]    mag;
   logic [11:0]    p;
   logic [31:0]    q32, t32, tsig, qsig;
   logic [24+FRAC_BITS-1:0] pfx_x, pfx_y;
   fctc_pkg::row_result_type res_ff;

   always_comb begin
      is_div = (state_ff == fctc_pkg::RS_RD) || (state_ff == fctc_pkg::RS_DIV_SX) ||
               (state_ff == fctc_pkg::RS_DIV_SY);
      is_mul = (state_ff == fctc_pkg::RS_MUL_SX) || (state_ff == fctc_pkg::RS_MUL_SY) ||
               (state_ff == fctc_pkg::RS_MUL_PX) || (state_ff == fctc_pkg::RS_MUL_PY);
      last   = (is_div && (cnt_ff == CW'(NW - 1))) ||
               (is_mul && (cnt_ff == CW'(MUL_LAST)));
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fctc_pkg::RS_IDLE: begin
            if (start) begin
               state_in = fctc_pkg::RS_RD;
            end
         end
         fctc_pkg::RS_RD:     if (last) state_in = fctc_pkg::RS_MUL_SX;
         fctc_pkg::RS_MUL_SX: if (last) state_in = fctc_pkg::RS_DIV_SX;
         fctc_pkg::RS_DIV_SX: if (last) state_in = fctc_pkg::RS_MUL_SY;
         fctc_pkg::RS_MUL_SY: if (last) state_in = fctc_pkg::RS_DIV_SY;
         fctc_pkg::RS_DIV_SY: if (last) state_in = fctc_pkg::RS_MUL_PX;
         fctc_pkg::RS_MUL_PX: if (last) state_in = fctc_pkg::RS_MUL_PY;
         fctc_pkg::RS_MUL_PY: if (last) state_in = fctc_pkg::RS_IDLE;
         default:             state_in = fctc_pkg::RS_IDLE;
      endcase
      cnt_in = (state_in != state_ff) ? '0 : cnt_ff + CW'(1);
   end

   always_comb begin
      trial  = {rem_ff, quo_ff[NW-1]};
      ge     = trial >= {1'b0, den_ff};
      rem_in = ge ? 12'(trial - {1'b0, den_ff}) : trial[11:0];
      quo_in = {quo_ff[NW-2:0], ge};
      acc_in = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
      rd_src = (state_ff == fctc_pkg::RS_RD) ? quo_in[RDW-1:0] : rd_ff;
      p      = row - {1'b0, cam.height[11:1]};
      case (state_in)
         fctc_pkg::RS_MUL_SX: vsel = {cam.plane_x[17], cam.plane_x, 1'b0};
         fctc_pkg::RS_MUL_SY: vsel = {cam.plane_y[17], cam.plane_y, 1'b0};
         fctc_pkg::RS_MUL_PX: vsel = {{2{cam.dir_x[17]}}, cam.dir_x} -
                                     {{2{cam.plane_x[17]}}, cam.plane_x};
         fctc_pkg::RS_MUL_PY: vsel = {{2{cam.dir_y[17]}}, cam.dir_y} -
                                     {{2{cam.plane_y[17]}}, cam.plane_y};
         default:             vsel = '0;
      endcase
      vneg  = 20'(0) - vsel;
      mag   = vsel[19] ? vneg[18:0] : vsel[18:0];
      q32   = 32'(quo_in);
      qsig  = sign_ff ? 32'(0) - q32 : q32;
      t32   = 32'(acc_in[PW-1:16]);
      tsig  = sign_ff ? 32'(0) - t32 : t32;
      pfx_x = {cam.pos_x, FRAC_BITS'(0)};
      pfx_y = {cam.pos_y, FRAC_BITS'(0)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fctc_pkg::RS_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= (state_ff == fctc_pkg::RS_MUL_PY) && last;
      end
   end

   always_ff @(posedge clock) begin
      if (state_in != state_ff) begin
         case (state_in)
            fctc_pkg::RS_RD: begin
               rem_ff <= '0;
               quo_ff <= NW'({cam.height, FRAC_BITS'(0)});
               den_ff <= {p[10:0], 1'b0};
            end
            fctc_pkg::RS_MUL_SX, fctc_pkg::RS_MUL_SY,
            fctc_pkg::RS_MUL_PX, fctc_pkg::RS_MUL_PY: begin
               acc_ff    <= '0;
               mcand_ff  <= PW'(rd_src);
               mplier_ff <= mag;
               sign_ff   <= vsel[19];
            end
            fctc_pkg::RS_DIV_SX, fctc_pkg::RS_DIV_SY: begin
               rem_ff <= '0;
               quo_ff <= NW'(acc_in[PW-1:16]);
               den_ff <= cam.width;
            end
            default: ;
         endcase
      end else if (is_div) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end else if (is_mul) begin
         acc_ff    <= acc_in;
         mcand_ff  <= {mcand_ff[PW-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[18:1]};
      end
      if (last) begin
         case (state_ff)
            fctc_pkg::RS_RD:     rd_ff         <= quo_in[RDW-1:0];
            fctc_pkg::RS_DIV_SX: res_ff.step_x <= qsig;
            fctc_pkg::RS_DIV_SY: res_ff.step_y <= qsig;
            fctc_pkg::RS_MUL_PX: res_ff.pos_x  <= 32'(pfx_x >> 16) + tsig;
            fctc_pkg::RS_MUL_PY: res_ff.pos_y  <= 32'(pfx_y >> 16) + tsig;
            default: ;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule
